// ===== hw/rtl/sroc_pkg.sv =====
// shared types, constants and helpers of the sorted row order checker
package sroc_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 1'd1;
  localparam logic [CFG_DATA_W-1:0] ROW_LENGTH_RESET = 7'd64;

  // character class bounds
  localparam logic [7:0] CH_DIGIT_LO = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI = 8'h39;
  localparam logic [7:0] CH_UPPER_LO = 8'h41;
  localparam logic [7:0] CH_UPPER_HI = 8'h5a;
  localparam logic [7:0] CH_LOWER_LO = 8'h61;
  localparam logic [7:0] CH_LOWER_HI = 8'h7a;

  // relation of the stored row to the incoming row so far
  typedef enum logic [1:0] {
    REL_EQUAL        = 2'd0,
    REL_PREV_LESS    = 2'd1,
    REL_PREV_GREATER = 2'd2
  } rel_e;

  // beat held between the memory read and the compare stage
  typedef struct packed {
    logic [7:0] row_byte;
    logic       row_end;
  } s1_beat_t;

  function automatic logic is_alnum(input logic [7:0] c);
    logic digit;
    logic upper;
    logic lower;
    digit = (c >= CH_DIGIT_LO) && (c <= CH_DIGIT_HI);
    upper = (c >= CH_UPPER_LO) && (c <= CH_UPPER_HI);
    lower = (c >= CH_LOWER_LO) && (c <= CH_LOWER_HI);
    return digit || upper || lower;
  endfunction

endpackage

// ===== hw/rtl/sroc_if.sv =====
// valid/ready channels of the sorted row order checker

interface sroc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] row_byte;

  modport source (output valid, output row_byte, input ready);
  modport sink   (input valid, input row_byte, output ready);
endinterface

interface sroc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       row_end;
  logic       sorted_so_far;
  logic       duplicates_seen;
  logic       bad_char;
  logic       error_seen;

  modport source (
    output valid, output data_byte, output row_end, output sorted_so_far,
    output duplicates_seen, output bad_char, output error_seen, input ready
  );
  modport sink (
    input valid, input data_byte, input row_end, input sorted_so_far,
    input duplicates_seen, input bad_char, input error_seen, output ready
  );
endinterface

// ===== hw/rtl/sroc_row_mem.sv =====
// previous row store: one read-first port, registered read data
module sroc_row_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  // old contents come out, new byte goes in at the same address
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q      <= mem_q[addr_i];
      mem_q[addr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sroc_cmp.sv =====
// compare stage: row relation, sticky flags and output register
module sroc_cmp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                descending_i,
  input  logic                s1_valid_i,
  input  sroc_pkg::s1_beat_t  s1_beat_i,
  input  logic [7:0]          prev_byte_i,
  output logic                s1_ready_o,
  sroc_out_if.source          out_o
);

  sroc_pkg::rel_e rel_q, rel_d, rel_new;
  logic first_q, first_d;
  logic sorted_q, sorted_d;
  logic dup_q, dup_d;
  logic err_q, err_d;
  logic bad;
  logic violation;
  logic advance;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_end_q;
  logic       out_bad_q;

  assign s1_ready_o = !out_valid_q || out_o.ready;
  assign advance    = s1_valid_i && s1_ready_o;

  always_comb begin
    rel_new = rel_q;
    if (rel_q == sroc_pkg::REL_EQUAL) begin
      if (prev_byte_i < s1_beat_i.row_byte) begin
        rel_new = sroc_pkg::REL_PREV_LESS;
      end else if (prev_byte_i > s1_beat_i.row_byte) begin
        rel_new = sroc_pkg::REL_PREV_GREATER;
      end
    end

    bad   = !sroc_pkg::is_alnum(s1_beat_i.row_byte);
    err_d = err_q || bad;

    violation = descending_i ? (rel_new == sroc_pkg::REL_PREV_LESS)
                             : (rel_new == sroc_pkg::REL_PREV_GREATER);

    rel_d    = rel_new;
    first_d  = first_q;
    sorted_d = sorted_q;
    dup_d    = dup_q;
    if (s1_beat_i.row_end) begin
      if (!first_q) begin
        if (violation) begin
          sorted_d = 1'b0;
        end else if (rel_new == sroc_pkg::REL_EQUAL) begin
          dup_d = 1'b1;
        end
      end
      first_d = 1'b0;
      rel_d   = sroc_pkg::REL_EQUAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rel_q       <= sroc_pkg::REL_EQUAL;
      first_q     <= 1'b1;
      sorted_q    <= 1'b1;
      dup_q       <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        rel_q    <= rel_d;
        first_q  <= first_d;
        sorted_q <= sorted_d;
        dup_q    <= dup_d;
        err_q    <= err_d;
      end
      if (s1_ready_o) begin
        out_valid_q <= s1_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= s1_beat_i.row_byte;
      out_end_q  <= s1_beat_i.row_end;
      out_bad_q  <= bad;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.data_byte       = out_byte_q;
  assign out_o.row_end         = out_end_q;
  assign out_o.sorted_so_far   = sorted_q;
  assign out_o.duplicates_seen = dup_q;
  assign out_o.bad_char        = out_bad_q;
  assign out_o.error_seen      = err_q;

  // a flagged byte is always reflected in the sticky error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_bad_q |-> err_q)
    else $error("bad_char without error_seen");

  // sorted flag only ever falls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sorted_q |=> !sorted_q)
    else $error("sorted flag rose");

  // relation is back to equal right after a row end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_beat_i.row_end |=> rel_q == sroc_pkg::REL_EQUAL)
    else $error("relation not cleared at row end");

endmodule

// ===== hw/rtl/sorted_row_order_checker.sv =====
// top level of the sorted row order checker
//
// usage: bytes of fixed-length rows arrive one per beat on in_i and leave
// unchanged on out_o, each with row_end, a per-byte bad_char flag and the
// sticky sorted_so_far, duplicates_seen and error_seen flags as they stand
// after that byte. each new row is compared byte by byte with the previous
// one; the first row after reset is only stored.
// config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 descending,
// 1 row_length); write only while no beat is in flight.
// throughput: one beat per cycle, sustained while out_o.ready stays high, with no bubbles at row ends.
// path: an accepted beat is registered into the compare stage, and that
// same edge reads the previous row memory; the compare stage then loads
// the output register, which drives out_o.valid.
// the memory is read-first, so a byte written at one accept is seen by a
// read of the same entry in the next (one-byte rows need no interlock).
// reset: flags return to sorted, no duplicates, no error; position goes
// to the row start; config to ascending, length 64; the row memory keeps
// its contents; the first row reads them but is not scored against them.
// stall: when out_o.ready is low the output register holds its beat, the
// compare stage fills once more and then in_i.ready drops.
module sorted_row_order_checker #(
  parameter int unsigned ROW_MAX = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sroc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sroc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  sroc_in_if.sink                           in_i,
  sroc_out_if.source                        out_o
);

  localparam int unsigned AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
  // wide enough for the row length register and for ROW_MAX itself
  localparam int unsigned CW = (AW + 1 > sroc_pkg::CFG_DATA_W) ? AW + 1
                                                               : sroc_pkg::CFG_DATA_W;
  localparam logic [CW-1:0] RowMaxC = CW'(ROW_MAX);

  // configuration registers
  logic                            desc_q;
  logic [sroc_pkg::CFG_DATA_W-1:0] row_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q    <= 1'b0;
      row_len_q <= sroc_pkg::ROW_LENGTH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sroc_pkg::CFG_DESCENDING: desc_q    <= cfg_data_i[0];
        sroc_pkg::CFG_ROW_LENGTH: row_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // row position and end of row
  logic [AW-1:0] pos_q, pos_d;
  logic [CW-1:0] rl_ext, len, pos_ext, pos_eff, pos_nxt;
  logic          row_end;

  always_comb begin
    rl_ext = CW'(row_len_q);
    if (row_len_q == '0) begin
      len = CW'(1);
    end else if (rl_ext > RowMaxC) begin
      len = RowMaxC;           // saturate to the memory depth
    end else begin
      len = rl_ext;
    end
    pos_ext = CW'(pos_q);
    // a length cut below the current position ends the row at once
    pos_eff = (pos_ext >= len) ? (len - CW'(1)) : pos_ext;
    pos_nxt = pos_eff + CW'(1);
    row_end = (pos_nxt >= len);
    pos_d   = row_end ? '0 : pos_nxt[AW-1:0];
  end

  // input handshake and compare stage register
  logic               accept;
  logic               s1_valid_q;
  logic               s1_ready;
  sroc_pkg::s1_beat_t s1_q;
  logic [7:0]         prev_byte;

  assign in_i.ready = !s1_valid_q || s1_ready;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_q <= pos_d;
      end
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.row_byte <= in_i.row_byte;
      s1_q.row_end  <= row_end;
    end
  end

  // previous row: old byte read out while the new byte replaces it
  sroc_row_mem #(
    .DEPTH (ROW_MAX)
  ) u_row_mem (
    .clk_i   (clk_i),
    .en_i    (accept),
    .addr_i  (pos_eff[AW-1:0]),
    .wdata_i (in_i.row_byte),
    .rdata_o (prev_byte)
  );

  sroc_cmp u_cmp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .descending_i (desc_q),
    .s1_valid_i   (s1_valid_q),
    .s1_beat_i    (s1_q),
    .prev_byte_i  (prev_byte),
    .s1_ready_o   (s1_ready),
    .out_o        (out_o)
  );

  // position register never leaves the memory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(pos_q) < RowMaxC)
    else $error("row position beyond memory depth");

  // a new beat only lands on a full compare stage that is draining
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s1_valid_q |-> s1_ready)
    else $error("compare stage overwritten");

  // error flag stays set once seen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.error_seen |=> !out_o.valid || out_o.error_seen)
    else $error("error flag cleared");

endmodule

// ===== verif/sorted_row_order_checker_test.sv =====
// self-checking testbench of the sorted row order checker: table, then random rows
`timescale 1ns / 1ps

module sorted_row_order_checker_test;

  localparam int unsigned ROW_MAX = 64;
  localparam int unsigned RANDOM_BYTES = 2000;

  // one output beat as the checker sees it
  typedef struct packed {
    logic [7:0] data_byte;
    logic       row_end;
    logic       sorted_so_far;
    logic       duplicates_seen;
    logic       bad_char;
    logic       error_seen;
  } row_result_t;

  // what the scoreboard should expect for one accepted input beat
  typedef struct packed {
    logic        typed;
    row_result_t want;
  } beat_plan_t;

  // one row of the directed table: a register write or a byte
  typedef struct packed {
    logic                            is_cfg;
    logic [sroc_pkg::CFG_IDX_W-1:0]  idx;
    logic [sroc_pkg::CFG_DATA_W-1:0] val;
    logic [7:0]                      b;
    logic                            typed;
    row_result_t                     want;
  } step_t;

  // receiver stall patterns, redrawn at random by the back-pressure process
  typedef enum logic [1:0] {
    FREE_RUN,
    COIN_FLIP,
    PERIODIC,
    STARVED
  } stall_e;

  // directed table; runs mostly at one-byte rows after the 64-byte priming row,
  // which leaves 63 '0' bytes and a trailing NUL in the row memory.
  // the expected beats typed here hold sorted, duplicates and error as they
  // stand once the priming row has set the error flag
  localparam int DIR_N = 28;
  localparam step_t DIR_TAB [DIR_N] = '{
    '{1'b1, sroc_pkg::CFG_ROW_LENGTH, 7'd1, 8'h00, 1'b0, '0},
    // ascending walk over the class edges; first byte equals the stored one
    '{1'b0, '0, '0, 8'h30, 1'b1, '{8'h30, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{1'b0, '0, '0, 8'h39, 1'b1, '{8'h39, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{1'b0, '0, '0, 8'h3a, 1'b1, '{8'h3a, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{1'b0, '0, '0, 8'h40, 1'b1, '{8'h40, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{1'b0, '0, '0, 8'h41, 1'b1, '{8'h41, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{1'b0, '0, '0, 8'h5a, 1'b1, '{8'h5a, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{1'b0, '0, '0, 8'h5b, 1'b1, '{8'h5b, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{1'b0, '0, '0, 8'h60, 1'b1, '{8'h60, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{1'b0, '0, '0, 8'h61, 1'b1, '{8'h61, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{1'b0, '0, '0, 8'h7a, 1'b1, '{8'h7a, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{1'b0, '0, '0, 8'h7b, 1'b1, '{8'h7b, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{1'b0, '0, '0, 8'h80, 1'b1, '{8'h80, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{1'b0, '0, '0, 8'hff, 1'b1, '{8'hff, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}},
    // descending walk back down to zero
    '{1'b1, sroc_pkg::CFG_DESCENDING, 7'd1, 8'h00, 1'b0, '0},
    '{1'b0, '0, '0, 8'hff, 1'b1, '{8'hff, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{1'b0, '0, '0, 8'h7a, 1'b1, '{8'h7a, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{1'b0, '0, '0, 8'h2f, 1'b1, '{8'h2f, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{1'b0, '0, '0, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{1'b0, '0, '0, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}},
    // zero length behaves as one
    '{1'b1, sroc_pkg::CFG_DESCENDING, 7'd0, 8'h00, 1'b0, '0},
    '{1'b1, sroc_pkg::CFG_ROW_LENGTH, 7'd0, 8'h00, 1'b0, '0},
    '{1'b0, '0, '0, 8'h30, 1'b1, '{8'h30, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}},
    // oversize length saturates, then shrinks below the position mid-row
    '{1'b1, sroc_pkg::CFG_ROW_LENGTH, 7'd127, 8'h00, 1'b0, '0},
    '{1'b0, '0, '0, 8'h41, 1'b1, '{8'h41, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{1'b0, '0, '0, 8'h42, 1'b1, '{8'h42, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{1'b1, sroc_pkg::CFG_ROW_LENGTH, 7'd2, 8'h00, 1'b0, '0},
    '{1'b0, '0, '0, 8'h43, 1'b1, '{8'h43, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                            cfg_we;
  logic [sroc_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [sroc_pkg::CFG_DATA_W-1:0] cfg_data;

  sroc_in_if  in_ch ();
  sroc_out_if out_ch ();

  sorted_row_order_checker #(
    .ROW_MAX(ROW_MAX)
  ) uut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_ch),
    .out_o     (out_ch)
  );

  always #4 clk = ~clk;

  // shadow of the checker state, advanced once per accepted input beat
  logic [7:0]                      last_row [ROW_MAX] = '{default: 8'h00};
  int unsigned                     row_pos = 0;
  sroc_pkg::rel_e                  row_rel = sroc_pkg::REL_EQUAL;
  logic                            first_row = 1'b1;
  logic                            sorted_flag = 1'b1;
  logic                            dup_flag = 1'b0;
  logic                            err_flag = 1'b0;
  // shadow registers, updated by the write task as it issues the write
  logic                            cur_desc = 1'b0;
  logic [sroc_pkg::CFG_DATA_W-1:0] cur_len = sroc_pkg::ROW_LENGTH_RESET;

  beat_plan_t  plan_q [$];     // queued by the driver, one per byte in flight
  row_result_t result_q [$];   // expected output beats, oldest first
  int unsigned mism_cnt = 0;
  int          burst_left = 0;
  int unsigned pat_cyc = 0;
  stall_e      pat_mode = FREE_RUN;

  // zero means one, anything above the row memory means the whole memory
  function automatic int unsigned eff_len(input logic [sroc_pkg::CFG_DATA_W-1:0] len);
    if (len == 0) return 1;
    if (len > ROW_MAX) return ROW_MAX;
    return len;
  endfunction

  function automatic logic alnum(input logic [7:0] c);
    return (c >= sroc_pkg::CH_DIGIT_LO && c <= sroc_pkg::CH_DIGIT_HI) ||
           (c >= sroc_pkg::CH_UPPER_LO && c <= sroc_pkg::CH_UPPER_HI) ||
           (c >= sroc_pkg::CH_LOWER_LO && c <= sroc_pkg::CH_LOWER_HI);
  endfunction

  function automatic logic [7:0] rand_alnum();
    int unsigned k;
    k = $urandom_range(0, 61);
    if (k < 10) return sroc_pkg::CH_DIGIT_LO + 8'(k);
    if (k < 36) return sroc_pkg::CH_UPPER_LO + 8'(k - 10);
    return sroc_pkg::CH_LOWER_LO + 8'(k - 36);
  endfunction

  // compares the byte against the stored row at the current position and
  // settles the sticky flags when the byte closes the row
  function automatic row_result_t predict_beat(input logic [7:0] b);
    row_result_t r;
    int unsigned len;
    int unsigned pos;
    logic        closes;
    len = eff_len(cur_len);
    pos = row_pos;
    // a length cut below the position ends the row on this byte
    if (pos >= len) pos = len - 1;
    // first differing byte decides the relation of the whole row
    if (row_rel == sroc_pkg::REL_EQUAL) begin
      if (last_row[pos] < b) row_rel = sroc_pkg::REL_PREV_LESS;
      else if (last_row[pos] > b) row_rel = sroc_pkg::REL_PREV_GREATER;
    end
    last_row[pos] = b;
    r.bad_char = !alnum(b);
    if (r.bad_char) err_flag = 1'b1;
    closes = (pos + 1 >= len);
    if (closes) begin
      // the row after reset has nothing to be compared with
      if (!first_row) begin
        if (cur_desc ? (row_rel == sroc_pkg::REL_PREV_LESS)
                     : (row_rel == sroc_pkg::REL_PREV_GREATER))
          sorted_flag = 1'b0;
        else if (row_rel == sroc_pkg::REL_EQUAL)
          dup_flag = 1'b1;
      end
      first_row = 1'b0;
      row_rel = sroc_pkg::REL_EQUAL;
      row_pos = 0;
    end else begin
      row_pos = pos + 1;
    end
    r.data_byte = b;
    r.row_end = closes;
    r.sorted_so_far = sorted_flag;
    r.duplicates_seen = dup_flag;
    r.error_seen = err_flag;
    return r;
  endfunction

  task automatic flag_beat(input string what, input row_result_t want,
                           input row_result_t got);
    mism_cnt++;
    if (mism_cnt <= 10) begin
      $display("%0t %s: want byte=%h end=%b sorted=%b dup=%b bad=%b err=%b",
               $realtime, what, want.data_byte, want.row_end, want.sorted_so_far,
               want.duplicates_seen, want.bad_char, want.error_seen);
      $display("    got byte=%h end=%b sorted=%b dup=%b bad=%b err=%b",
               got.data_byte, got.row_end, got.sorted_so_far, got.duplicates_seen,
               got.bad_char, got.error_seen);
    end
  endtask

  // scoreboard: every signal is read before the edge's updates land
  always @(posedge clk) begin : scoreboard
    row_result_t got;
    row_result_t model;
    beat_plan_t  plan;
    if (rst_n) begin
      // output side first: a beat leaving now never belongs to one entering now
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.data_byte, out_ch.row_end, out_ch.sorted_so_far,
                out_ch.duplicates_seen, out_ch.bad_char, out_ch.error_seen};
        if (result_q.size() == 0)
          flag_beat("beat with nothing expected", '0, got);
        else if (got !== result_q[0])
          flag_beat("beat mismatch", result_q.pop_front(), got);
        else
          void'(result_q.pop_front());
      end
      if (in_ch.valid && in_ch.ready) begin
        plan = plan_q.pop_front();
        model = predict_beat(in_ch.row_byte);
        // a typed expectation from the table takes the place of the prediction
        result_q.push_back(plan.typed ? plan.want : model);
      end
    end
  end

  // receiver back-pressure in a stall pattern that is redrawn at random
  always @(posedge clk) begin
    pat_cyc <= pat_cyc + 1;
    if (pat_cyc % 300 == 0) pat_mode <= stall_e'($urandom_range(0, 3));
    case (pat_mode)
      FREE_RUN:  out_ch.ready <= 1'b1;
      COIN_FLIP: out_ch.ready <= 1'($urandom_range(0, 1));
      PERIODIC:  out_ch.ready <= (pat_cyc % 7) >= 3;
      default:   out_ch.ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // sends one byte, maybe opening a gap first when the current burst is used up;
  // returns at the edge that accepts the beat
  task automatic send_byte(input logic [7:0] b, input logic typed,
                           input row_result_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    plan_q.push_back('{typed, want});
    in_ch.valid <= 1'b1;
    in_ch.row_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // register writes wait until every beat in flight has come out
  task automatic write_reg(input logic [sroc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sroc_pkg::CFG_DATA_W-1:0] val);
    in_ch.valid <= 1'b0;
    while (result_q.size() != 0 || plan_q.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    if (idx == sroc_pkg::CFG_DESCENDING) cur_desc = val[0];
    else if (idx == sroc_pkg::CFG_ROW_LENGTH) cur_len = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // next row for the random part: mostly an in-order successor or a repeat
  // of the row before, sometimes a free alnum row or raw noise
  function automatic void build_row(output logic [7:0] row [ROW_MAX],
                                    input logic [7:0] prior [ROW_MAX],
                                    input int unsigned len);
    int unsigned kind;
    int unsigned k;
    int unsigned i;
    logic [7:0]  c;
    logic        found;
    kind = $urandom_range(0, 99);
    row = prior;
    if (kind < 15) begin
      // duplicate row, kept as copied
    end else if (kind < 80) begin
      // keep a random prefix, step past the stored byte in the set direction
      k = $urandom_range(0, len - 1);
      found = 1'b0;
      for (i = 0; i < 8 && !found; i++) begin
        c = rand_alnum();
        found = cur_desc ? (c < prior[k]) : (c > prior[k]);
      end
      if (!found) begin
        if (!cur_desc && prior[k] != 8'hff) c = 8'($urandom_range(prior[k] + 1, 255));
        else if (cur_desc && prior[k] != 8'h00) c = 8'($urandom_range(0, prior[k] - 1));
        else c = prior[k];
      end
      row[k] = c;
      for (i = k + 1; i < len; i++) row[i] = rand_alnum();
    end else if (kind < 92) begin
      for (i = 0; i < len; i++) row[i] = rand_alnum();
    end else begin
      for (i = 0; i < len; i++) row[i] = 8'($urandom_range(0, 255));
    end
  endfunction

  // one stretch of random rows under fixed settings; starts wherever the
  // previous stretch left the row, which may be mid-row
  task automatic run_phase(input int n_items);
    logic [7:0]  fresh [ROW_MAX];
    logic [7:0]  mirror [ROW_MAX];
    int unsigned len;
    int unsigned pos;
    int unsigned i;
    len = eff_len(cur_len);
    pos = (row_pos >= len) ? len - 1 : row_pos;
    mirror = last_row;
    while (n_items > 0) begin
      build_row(fresh, mirror, len);
      for (i = pos; i < len && n_items > 0; i++) begin
        send_byte(fresh[i], 1'b0, '0);
        mirror[i] = fresh[i];
        n_items--;
      end
      pos = 0;
    end
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned n;
    int unsigned pick;
    logic [sroc_pkg::CFG_DATA_W-1:0] len;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.row_byte <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // priming row at the reset length fills the whole row memory, so no
    // later length can reach an entry that was never written
    for (int i = 0; i < ROW_MAX; i++)
      send_byte((i == ROW_MAX - 1) ? 8'h00 : sroc_pkg::CH_DIGIT_LO, 1'b0, '0);

    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_TAB[i].is_cfg) write_reg(DIR_TAB[i].idx, DIR_TAB[i].val);
      else send_byte(DIR_TAB[i].b, DIR_TAB[i].typed, DIR_TAB[i].want);
    end

    // random stretches, settings reshuffled between them
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 1) == 1)
        write_reg(sroc_pkg::CFG_DESCENDING, 7'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) != 0) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) len = 7'd0;
        else if (pick == 1) len = 7'($urandom_range(ROW_MAX + 1, 127));
        else if (pick < 4) len = 7'(ROW_MAX);
        else if (pick == 4) len = 7'd1;
        else len = 7'($urandom_range(2, 8));
        write_reg(sroc_pkg::CFG_ROW_LENGTH, len);
      end
      n = $urandom_range(40, 200);
      run_phase(n);
      sent += n;
    end

    in_ch.valid <= 1'b0;
    while (result_q.size() != 0 || plan_q.size() != 0) @(posedge clk);
    // room for any stray beat to show up
    repeat (8) @(posedge clk);
    if (mism_cnt == 0)
      $display("sorted_row_order_checker_test: done, clean");
    else
      $display("sorted_row_order_checker_test: done, errors");
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("sorted_row_order_checker_test: done, errors");
    $finish;
  end

endmodule

// ===== sorted_row_order_checker.f =====
hw/rtl/sroc_pkg.sv
hw/rtl/sroc_if.sv
hw/rtl/sroc_row_mem.sv
hw/rtl/sroc_cmp.sv
hw/rtl/sorted_row_order_checker.sv
verif/sorted_row_order_checker_test.sv
